/* sv/vnl_pkg.sv */
// vnl_pkg: types, constants and helper functions for the voice noise / control block.
// No dependencies; imported by vnl_voice and voice_noise_lfsr_control.
`default_nettype none

package vnl_pkg;

   localparam int LfsrWidth = 23;
   localparam int NoiseWidth = 12;
   localparam int WaveWidth = 4;

   localparam logic [LfsrWidth-1:0] LFSR_RESET = 23'h7ffffc;
   localparam logic [LfsrWidth-1:0] TAP_MASK =
      23'h400000 | 23'h100000 | 23'h010000 | 23'h002000 |
      23'h000800 | 23'h000080 | 23'h000010 | 23'h000004;
   localparam logic [WaveWidth-1:0] WAVE_NOISE_ONLY = 4'd8;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] control_byte;
   } req_type;

   typedef struct packed {
      logic [NoiseWidth-1:0] noise_out;
      logic                  clear_accumulator;
      logic [WaveWidth-1:0]  waveform_select;
      logic                  test_active;
      logic                  ring_enable;
      logic                  sync_enable;
   } rsp_type;

   function automatic logic [LfsrWidth-1:0] lfsr_shift(input logic [LfsrWidth-1:0] r);
      return {r[LfsrWidth-2:0], r[22] ^ r[17]};
   endfunction

   function automatic logic [NoiseWidth-1:0] gather_taps(input logic [LfsrWidth-1:0] r);
      return {r[22], r[20], r[16], r[13], r[11], r[7], r[4], r[2], 4'b0000};
   endfunction

endpackage

`default_nettype wire

/* sv/voice_noise_lfsr_control.sv */
// voice_noise_lfsr_control: top level, voice state plus registered result stage.
// Depends on vnl_pkg and vnl_voice.
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | vnl_pkg::req_type
//   rsp     | out       | rsp_valid/stall  | vnl_pkg::rsp_type
//
// One transfer per clock while rsp is not stalled; its result appears in the next cycle from the result register.
// The state update is combinational shift/decode logic, so throughput is one per cycle unless rsp stalls.
// Synchronous reset loads the shift register with 0x7ffffc and clears the control bits.
// req_stall is high only while a held result is stalled on rsp.
`default_nettype none

module voice_noise_lfsr_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire vnl_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output vnl_pkg::rsp_type      rsp_data
);
   import vnl_pkg::*;

   logic    accept;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_next;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;

   vnl_voice u_voice (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .req      (req_data),
      .rsp_next (rsp_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(accept && rsp_valid_ff && rsp_stall))
      else $error("transfer accepted over a stalled result");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transfer produced no result");

   a_clear_implies_test: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.clear_accumulator) |-> rsp_data.test_active)
      else $error("accumulator clear without test bit");

   a_low_nibble_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.noise_out[3:0] == 4'b0000))
      else $error("noise low bits not zero");
`endif

endmodule

`default_nettype wire

/* sv/vnl_voice.sv */
// vnl_voice: noise shift register and control bits, with next-state decode.
// Depends on vnl_pkg. Presents the result of the transfer being taken.
`default_nettype none

module vnl_voice (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire vnl_pkg::req_type req,
   output vnl_pkg::rsp_type     rsp_next
);
   import vnl_pkg::*;

   logic [LfsrWidth-1:0] lfsr_ff, lfsr_in;
   logic                 test_ff, test_in;
   logic [WaveWidth-1:0] wave_ff, wave_in;
   logic                 ring_ff, ring_in;
   logic                 sync_ff, sync_in;
   logic                 clear_acc;

   always_comb begin
      logic [LfsrWidth-1:0] r;
      r = lfsr_ff;
      test_in = test_ff;
      wave_in = wave_ff;
      ring_in = ring_ff;
      sync_in = sync_ff;
      clear_acc = 1'b0;
      unique case (req.operation)
         OP_TICK: begin
            r = lfsr_shift(r);
         end
         OP_WRITE: begin
            wave_in = req.control_byte[7:4];
            test_in = req.control_byte[3];
            ring_in = req.control_byte[2];
            sync_in = req.control_byte[1];
            if (test_in && !test_ff) begin
               r[1] = ~r[19];
               clear_acc = 1'b1;
            end
            if (!test_in && test_ff) begin
               r = lfsr_shift(r);
            end
         end
         default: begin
         end
      endcase
      if (wave_in > WAVE_NOISE_ONLY) begin
         r = r & ~TAP_MASK;
      end
      lfsr_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_RESET;
         test_ff <= 1'b0;
         wave_ff <= '0;
         ring_ff <= 1'b0;
         sync_ff <= 1'b0;
      end else if (load) begin
         lfsr_ff <= lfsr_in;
         test_ff <= test_in;
         wave_ff <= wave_in;
         ring_ff <= ring_in;
         sync_ff <= sync_in;
      end
   end

   assign rsp_next = '{
      noise_out:         gather_taps(lfsr_in),
      clear_accumulator: clear_acc,
      waveform_select:   wave_in,
      test_active:       test_in,
      ring_enable:       ring_in,
      sync_enable:       sync_in
   };

endmodule

`default_nettype wire
